// ===== design/pse_pkg.sv =====
// Package for the postfix stack evaluator: widths, codes, token and queue types.
// No dependencies.
package pse_pkg;

  localparam int DATA_W = 32;
  localparam int STACK_DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4
  } op_code_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_LEFTOVER  = 3'd4
  } status_t;

  // Token as queued between front and back.
  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] value;
    logic [2:0]        op_code;
    logic              last_token;
  } token_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_EXEC,
    BK_DIV,
    BK_WRITE,
    BK_EMIT
  } bk_state_t;

  // Divider handshake between back end and divider.
  typedef struct packed {
    logic              start;
    logic              want_rem;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] res;
  } div_rsp_t;

endpackage

// ===== design/pse_if.sv =====
// Valid/ready channel interfaces for the postfix stack evaluator.
// Depends on pse_pkg.
interface pse_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [pse_pkg::DATA_W-1:0] operand_value;
  logic [2:0]                op_code;
  logic                      last_token;
  modport source (output valid, mode, operand_value, op_code, last_token, input ready);
  modport sink (input valid, mode, operand_value, op_code, last_token, output ready);
endinterface

interface pse_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [pse_pkg::DATA_W-1:0] result_value;
  logic [2:0]                status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

// ===== design/pse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== design/pse_front.sv =====
// Front end: accept tokens and queue them for the back end (two-entry FIFO).
// Depends on pse_pkg and pse_if.
module pse_front (
  input  logic            clk,
  input  logic            rst_n,
  pse_in_if.sink          in_ch,
  output pse_pkg::token_t tok,
  output logic            tok_valid,
  input  logic            tok_pop
);
  pse_pkg::token_t q_r [2];
  pse_pkg::token_t in_tok;
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign tok = q_r[rd_r];
  assign tok_valid = (cnt_r != 2'd0);

  always_comb begin
    in_tok.mode = in_ch.mode;
    in_tok.value = in_ch.operand_value;
    in_tok.op_code = in_ch.op_code;
    in_tok.last_token = in_ch.last_token;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, tok_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (tok_pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= in_tok;
  end
endmodule

// ===== design/pse_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating.
// Depends on pse_pkg.
module pse_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pse_pkg::div_req_t req,
  output pse_pkg::div_rsp_t rsp
);
  localparam int W = pse_pkg::DATA_W;
  logic [W-1:0] q_r, d_r;
  logic [W:0]   rem_r;
  logic [$clog2(W)-1:0] cnt_r;
  logic busy_r, neg_q_r, neg_r_r, rem_sel_r, done_r;
  logic [W:0] trial;
  logic [W:0] shifted;
  logic [W-1:0] res;

  always_comb begin
    shifted = {rem_r[W-1:0], q_r[W-1]};
    trial = shifted - {1'b0, d_r};
    if (rem_sel_r) res = neg_r_r ? (W'(0) - rem_r[W-1:0]) : rem_r[W-1:0];
    else res = neg_q_r ? (W'(0) - q_r) : q_r;
    rsp.done = done_r;
    rsp.res = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        q_r <= req.num[W-1] ? (W'(0) - req.num) : req.num;
        d_r <= req.den[W-1] ? (W'(0) - req.den) : req.den;
        rem_r <= '0;
        neg_q_r <= req.num[W-1] ^ req.den[W-1];
        neg_r_r <= req.num[W-1];
        rem_sel_r <= req.want_rem;
      end else if (busy_r) begin
        if (!trial[W]) begin
          rem_r <= trial;
          q_r <= {q_r[W-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r <= {q_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + ($clog2(W))'(1);
        if (cnt_r == ($clog2(W))'(W-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== design/pse_back.sv =====
// Back end: stack sequencer over the operand RAM, arithmetic and result register.
// Depends on pse_pkg, pse_if, pse_ram and pse_div.
module pse_back #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pse_pkg::token_t tok,
  input  logic            tok_valid,
  output logic            tok_pop,
  pse_out_if.source       out_ch
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int W = pse_pkg::DATA_W;

  pse_pkg::bk_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  logic [2:0]    err_r;
  logic [W-1:0]  top_r;       // cached top of stack
  logic          ovalid_r;
  logic [W-1:0]  ores_r;
  logic [2:0]    ostat_r;
  logic [W-1:0]  rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [W-1:0]  wr_data;
  pse_pkg::div_req_t dreq;
  pse_pkg::div_rsp_t drsp;
  logic          is_div, push_ok, op_ok;
  logic          load_out;
  logic [W-1:0]  alu;
  logic [2:0]    fstat;

  pse_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  pse_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Top lives in top_r; RAM holds entries below it. Entry i at address i.
  assign push_ok = (cnt_r < CW'(STACK_DEPTH));
  assign op_ok = (cnt_r >= CW'(2));
  assign is_div = (tok.op_code != pse_pkg::OP_ADD) && (tok.op_code != pse_pkg::OP_SUB)
                  && (tok.op_code != pse_pkg::OP_MUL);
  assign rd_addr = AW'(cnt_r - CW'(2));
  assign load_out = (state_r == pse_pkg::BK_EMIT) && (!ovalid_r || out_ch.ready);

  always_comb begin
    case (tok.op_code)
      pse_pkg::OP_ADD: alu = rd_data + top_r;
      pse_pkg::OP_SUB: alu = rd_data - top_r;
      default:         alu = W'(rd_data * top_r);
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pse_pkg::BK_IDLE: begin
        if (tok_valid) begin
          if (!tok.mode || !op_ok) state_nxt = tok.last_token ? pse_pkg::BK_EMIT
                                                             : pse_pkg::BK_WRITE;
          else state_nxt = pse_pkg::BK_READ;
        end
      end
      pse_pkg::BK_READ: state_nxt = pse_pkg::BK_EXEC;
      pse_pkg::BK_EXEC: begin
        if (is_div && top_r != '0) state_nxt = pse_pkg::BK_DIV;
        else state_nxt = tok.last_token ? pse_pkg::BK_EMIT : pse_pkg::BK_WRITE;
      end
      pse_pkg::BK_DIV: if (drsp.done) state_nxt = tok.last_token ? pse_pkg::BK_EMIT
                                                                 : pse_pkg::BK_WRITE;
      pse_pkg::BK_WRITE: state_nxt = pse_pkg::BK_IDLE;
      pse_pkg::BK_EMIT: if (!ovalid_r || out_ch.ready) state_nxt = pse_pkg::BK_IDLE;
      default: state_nxt = pse_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    dreq.start = (state_r == pse_pkg::BK_EXEC) && is_div && (top_r != '0);
    dreq.want_rem = (tok.op_code != pse_pkg::OP_DIV);
    dreq.num = rd_data;
    dreq.den = top_r;
    // Spill the old top to RAM when a push lands on a nonempty stack.
    wr_en = (state_r == pse_pkg::BK_IDLE) && tok_valid && !tok.mode && push_ok
            && (cnt_r != '0);
    wr_addr = AW'(cnt_r - CW'(1));
    wr_data = top_r;
    tok_pop = (state_r == pse_pkg::BK_WRITE) ||
              ((state_r == pse_pkg::BK_EMIT) && (!ovalid_r || out_ch.ready));
  end

  always_comb begin
    if (err_r != pse_pkg::ST_OK) fstat = err_r;
    else if (cnt_r == '0) fstat = pse_pkg::ST_UNDERFLOW;
    else if (cnt_r > CW'(1)) fstat = pse_pkg::ST_LEFTOVER;
    else fstat = pse_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pse_pkg::BK_IDLE;
      cnt_r <= '0;
      err_r <= pse_pkg::ST_OK;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        pse_pkg::BK_IDLE: begin
          if (tok_valid) begin
            if (!tok.mode) begin
              if (push_ok) begin
                top_r <= tok.value;
                cnt_r <= cnt_r + CW'(1);
              end else if (err_r == pse_pkg::ST_OK) begin
                err_r <= pse_pkg::ST_OVERFLOW;
              end
            end else if (!op_ok && err_r == pse_pkg::ST_OK) begin
              err_r <= pse_pkg::ST_UNDERFLOW;
            end
          end
        end
        pse_pkg::BK_EXEC: begin
          cnt_r <= cnt_r - CW'(1);
          if (!is_div) top_r <= alu;
          else if (top_r == '0) begin
            top_r <= '0;
            if (err_r == pse_pkg::ST_OK) err_r <= pse_pkg::ST_DIVZERO;
          end
        end
        pse_pkg::BK_DIV: if (drsp.done) top_r <= drsp.res;
        pse_pkg::BK_EMIT: begin
          if (load_out) begin
            ostat_r <= fstat;
            ores_r <= (fstat == pse_pkg::ST_OK || fstat == pse_pkg::ST_LEFTOVER)
                      ? top_r : '0;
            cnt_r <= '0;
            err_r <= pse_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.result_value = ores_r;
  assign out_ch.status = ostat_r;
endmodule

// ===== design/postfix_stack_evaluator.sv =====
// Postfix stack evaluator. A push passes the back-end states idle and write; add/sub/mul
// pass idle, read, exec and write; divide/remainder with a nonzero divisor add a div state
// that waits on the one-bit-a-cycle divider. The last token takes the emit state in place
// of write and loads the result register there.
// A stalled result holds the back end in its emit state.
// Synchronous active-low reset clears stack count, error and handshakes; RAM is kept.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pse_in_if.sink    in_ch,
  pse_out_if.source out_ch
);
  pse_pkg::token_t tok;
  logic            tok_valid;
  logic            tok_pop;

  // Front: accept and queue tokens.
  pse_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .tok(tok), .tok_valid(tok_valid), .tok_pop(tok_pop)
  );

  // Back: execute tokens against the stack, emit results.
  pse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .tok(tok), .tok_valid(tok_valid),
    .tok_pop(tok_pop), .out_ch(out_ch)
  );

`ifndef SYNTHESIS
  // Never pop an empty queue.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    tok_pop |-> tok_valid) else $error("pop from empty token queue");
  // A held result stays until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
    else $error("result dropped while stalled");
`endif
endmodule

// ===== tb/tb_pse_if.sv =====
`timescale 1ns / 100ps
// Shared testbench types for the evaluator: token and result records.
// Depends on pse_pkg.
package tb_pse_types;

  typedef struct {
    logic                       mode;
    logic [pse_pkg::DATA_W-1:0] value;
    logic [2:0]                 op_code;
    logic                       last_token;
  } tb_token_t;

  typedef struct {
    logic [pse_pkg::DATA_W-1:0] result_value;
    logic [2:0]                 status;
  } tb_result_t;
endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for postfix_stack_evaluator: directed and random postfix token streams,
// checked against an in-bench stack evaluator. Depends on pse_pkg, pse_if, tb_pse_types.
module tb;

  localparam int DEPTH = pse_pkg::STACK_DEPTH_DEF;
  localparam int DW = pse_pkg::DATA_W;

  logic clk;
  logic rst_n;

  pse_in_if  in_ch ();
  pse_out_if out_ch ();

  postfix_stack_evaluator #(.STACK_DEPTH(DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Clock: 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor state: our own copy of the evaluator stack.
  logic [DW-1:0]               eval_stack [DEPTH];
  int unsigned                 eval_count;
  pse_pkg::status_t            eval_err;
  tb_pse_types::tb_result_t    pending_results [$];

  int unsigned n_fail = 0;
  int unsigned n_tokens;
  int unsigned n_results = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          recv_hold;

  function automatic void note_fault(pse_pkg::status_t code);
    if (eval_err == pse_pkg::ST_OK) eval_err = code;
  endfunction

  function automatic logic [DW-1:0] mag32(logic [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  // Advance the predictor by one token; queue a result on the last token.
  function automatic void evaluate_token(tb_pse_types::tb_token_t t);
    logic [DW-1:0] rhs, lhs, res, ma, mb, q;
    pse_pkg::status_t         st;
    tb_pse_types::tb_result_t r;
    if (!t.mode) begin
      if (eval_count >= DEPTH) note_fault(pse_pkg::ST_OVERFLOW);
      else begin
        eval_stack[eval_count] = t.value;
        eval_count++;
      end
    end else if (eval_count < 2) begin
      note_fault(pse_pkg::ST_UNDERFLOW);
    end else begin
      rhs = eval_stack[eval_count-1];
      lhs = eval_stack[eval_count-2];
      eval_count -= 2;
      case (t.op_code)
        pse_pkg::OP_ADD: res = lhs + rhs;
        pse_pkg::OP_SUB: res = lhs - rhs;
        pse_pkg::OP_MUL: res = lhs * rhs;
        default: begin
          if (rhs == '0) begin
            note_fault(pse_pkg::ST_DIVZERO);
            res = '0;
          end else begin
            ma = mag32(lhs);
            mb = mag32(rhs);
            if (t.op_code == pse_pkg::OP_DIV) begin
              q = ma / mb;
              res = (lhs[DW-1] ^ rhs[DW-1]) ? (~q + DW'(1)) : q;
            end else begin
              q = ma % mb;
              res = lhs[DW-1] ? (~q + DW'(1)) : q;
            end
          end
        end
      endcase
      eval_stack[eval_count] = res;
      eval_count++;
    end
    if (!t.last_token) return;
    if (eval_err != pse_pkg::ST_OK) st = eval_err;
    else if (eval_count == 0) st = pse_pkg::ST_UNDERFLOW;
    else if (eval_count > 1) st = pse_pkg::ST_LEFTOVER;
    else st = pse_pkg::ST_OK;
    r.status = st;
    r.result_value = ((st == pse_pkg::ST_OK || st == pse_pkg::ST_LEFTOVER) &&
                      eval_count >= 1) ? eval_stack[eval_count-1] : '0;
    pending_results.insert(pending_results.size(), r);
    eval_count = 0;
    eval_err = pse_pkg::ST_OK;
  endfunction

  // Send one token: hold valid until accepted, predict on acceptance.
  task automatic send_token(tb_pse_types::tb_token_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= t.mode;
    in_ch.operand_value <= t.value;
    in_ch.op_code       <= t.op_code;
    in_ch.last_token    <= t.last_token;
    do @(posedge clk); while (!in_ch.ready);
    evaluate_token(t);
    n_tokens++;
  endtask

  // Drop valid and wait on the clock before anything else drives the input.
  task automatic release_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_val(logic [DW-1:0] v, bit last = 0);
    tb_pse_types::tb_token_t t;
    t.mode = 0; t.value = v; t.op_code = 3'($urandom); t.last_token = last;
    send_token(t);
  endtask

  task automatic push_op(logic [2:0] op, bit last = 0);
    tb_pse_types::tb_token_t t;
    t.mode = 1; t.value = $urandom; t.op_code = op; t.last_token = last;
    send_token(t);
  endtask

  // Pause the sender until every expected result has arrived or a guard count runs out.
  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  // Receiver: randomly stall ready; compare each result with the oldest expectation.
  always @(posedge clk) begin
    tb_pse_types::tb_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no expectation: value=%0d status=%0d",
                 $signed(out_ch.result_value), out_ch.status);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          n_results++;
          if (out_ch.result_value !== want.result_value) begin
            $error("result_value: expected %0d actual %0d",
                   $signed(want.result_value), $signed(out_ch.result_value));
            n_fail++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_ch.status);
            n_fail++;
          end
        end
      end
      out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Directed: operators, wrap, divide corner cases, every status code but overflow.
  task automatic test_directed();
    push_val(32'h7fffffff); push_val(32'd1); push_op(pse_pkg::OP_ADD, 1);  // wrap add
    push_val(32'h80000000); push_val(32'd1); push_op(pse_pkg::OP_SUB, 1);  // wrap sub
    push_val(32'hffffffff); push_val(32'h80000000); push_op(pse_pkg::OP_MUL, 1);
    // most negative divided by minus one
    push_val(32'h80000000); push_val(32'hffffffff); push_op(pse_pkg::OP_DIV, 1);
    push_val(32'h80000000); push_val(32'hffffffff); push_op(pse_pkg::OP_REM, 1);
    push_val(-32'sd7); push_val(32'd2); push_op(pse_pkg::OP_DIV, 1);       // truncating
    push_val(-32'sd7); push_val(32'd2); push_op(pse_pkg::OP_REM, 1);
    push_val(32'd9); push_val(32'd0); push_op(pse_pkg::OP_DIV);            // divide by zero
    push_val(32'd3); push_op(3'd7, 1);                         // unused code acts as remainder
    push_op(pse_pkg::OP_ADD, 1);                                           // underflow
    push_val(32'd5); push_val(32'd6, 1);                                   // leftover operands
    push_val(32'd0, 1);                                                    // single ok
  endtask

  // Directed: fill the stack past its depth to provoke overflow.
  task automatic test_overflow();
    for (int i = 0; i < DEPTH; i++) push_val($urandom);
    push_val(32'd1);
    push_op(pse_pkg::OP_ADD, 1);
  endtask

  // Random well-formed expressions with noise and broken sequences mixed in.
  task automatic test_random(int unsigned count);
    int unsigned depth_now, len, stop;
    tb_pse_types::tb_token_t t;
    stop = n_tokens + count;
    while (n_tokens < stop) begin
      len = $urandom_range(9) + 1;
      depth_now = 0;
      if ($urandom_range(9) < 8) begin
        // well-formed: push operands, reduce to one, occasionally stray
        for (int i = 0; i < len; i++) begin
          t.mode = (depth_now >= 2) && ($urandom_range(1) == 1);
          t.value = ($urandom_range(3) == 0) ? $urandom_range(3) - 1 : $urandom;
          if ($urandom_range(7) == 0)
            t.value = {1'($urandom_range(1)), {31{$urandom_range(1) == 1}}};
          t.op_code = 3'($urandom_range(4));
          t.last_token = 0;
          if (t.mode) depth_now--; else depth_now++;
          send_token(t);
        end
        while (depth_now > 1) begin
          t.mode = 1; t.value = $urandom; t.op_code = 3'($urandom_range(4));
          t.last_token = (depth_now == 2) && ($urandom_range(7) != 0);
          depth_now--;
          send_token(t);
          if (t.last_token) depth_now = 0;
        end
        if (depth_now != 0 || $urandom_range(1)) begin
          t.mode = 1'($urandom_range(1)); t.value = $urandom; t.op_code = 3'($urandom);
          t.last_token = 1;
          send_token(t);
        end
      end else begin
        for (int i = 0; i < len; i++) begin
          t.mode = 1'($urandom_range(1)); t.value = $urandom; t.op_code = 3'($urandom);
          t.last_token = (i == len - 1) || ($urandom_range(9) == 0);
          send_token(t);
        end
      end
    end
  endtask

  // Hold the receiver off for a long stretch so the block stalls its input.
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1;
        repeat (400) @(posedge clk);
        recv_hold = 0;
      end
      begin
        for (int i = 0; i < 10; i++) begin
          push_val($urandom); push_val($urandom); push_op(3'($urandom_range(2)), 1);
        end
        release_input();
      end
    join
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.operand_value = '0;
    in_ch.op_code = '0;
    in_ch.last_token = 1'b0;
    eval_count = 0;
    eval_err = pse_pkg::ST_OK;
    n_tokens = 0;
    recv_hold = 0;
    send_idle_pct = 22; recv_idle_pct = 79;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_overflow();
    release_input();
    drain_results();
    test_random(400);
    send_idle_pct = 79; recv_idle_pct = 22;
    test_random(400);
    release_input();
    drain_results();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(400);
    release_input();
    drain_results();

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
    end
    $display("Covered %0d tokens and %0d expression results across all operators,",
             n_tokens, n_results);
    $display("stack overflow/underflow, divide by zero and three handshake profiles.");
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
